// ----- design/relevance_sorted_event_list_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the relevance sorted event list
// ---------------------------------------------------------------------------
`ifndef RELEVANCE_SORTED_EVENT_LIST_DEFINES_SVH
`define RELEVANCE_SORTED_EVENT_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define RSEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define RSEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rsel_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsel_pkg
// Shared types and constants of the relevance sorted event list.
// ---------------------------------------------------------------------------
package rsel_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } rsel_kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } rsel_status_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [3:0]  etype;
    logic [3:0]  rel;
  } rsel_ent_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    logic      ins;
    logic      pop;
    rsel_ent_t ent;
  } rsel_ctrl_t;

endpackage

// ----- design/rsel_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsel_in_if / rsel_out_if
// Valid/ready channels for operations and results.
// ---------------------------------------------------------------------------
interface rsel_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [13:0] ev_year;
  logic [3:0]  ev_month;
  logic [4:0]  ev_day;
  logic [3:0]  ev_type;
  logic [3:0]  relevance;

  modport source (output valid, kind, ev_year, ev_month, ev_day, ev_type, relevance,
                  input ready);
  modport sink   (input valid, kind, ev_year, ev_month, ev_day, ev_type, relevance,
                  output ready);
endinterface

interface rsel_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        head_valid;
  logic [13:0] head_year;
  logic [3:0]  head_month;
  logic [4:0]  head_day;
  logic [3:0]  head_type;
  logic [3:0]  head_relevance;
  logic [6:0]  entry_count;

  modport source (output valid, status, head_valid, head_year, head_month, head_day,
                         head_type, head_relevance, entry_count,
                  input ready);
  modport sink   (input valid, status, head_valid, head_year, head_month, head_day,
                        head_type, head_relevance, entry_count,
                  output ready);
endinterface

// ----- design/rsel_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsel_cell
// One list slot: keeps its entry, takes the new one, or shifts from a neighbor.
// ---------------------------------------------------------------------------
module rsel_cell
  import rsel_pkg::*;
(
  input  logic       clk_i,
  input  rsel_ctrl_t ctrl_i,
  input  logic       occ_i,       // slot holds a live entry
  input  logic       left_gt_i,   // left neighbor stays ahead of the new entry
  input  rsel_ent_t  left_ent_i,
  input  rsel_ent_t  right_ent_i,
  output logic       gt_o,
  output rsel_ent_t  ent_o,
  output rsel_ent_t  ent_d_o
);

  rsel_ent_t ent_q;
  rsel_ent_t ent_d;

  assign gt_o = occ_i && (ent_q.rel > ctrl_i.ent.rel);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      // Stay put if strictly more relevant; otherwise the new entry lands at the
      // first slot that is not, and everything behind it moves back one.
      if (!gt_o) begin
        ent_d = left_gt_i ? ctrl_i.ent : left_ent_i;
      end
    end else if (ctrl_i.pop) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign ent_d_o = ent_d;

endmodule

// ----- design/relevance_sorted_event_list.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// relevance_sorted_event_list
// Bounded event list sorted by relevance, built as a row of shifting cells.
// ---------------------------------------------------------------------------
// Channel  Dir  Transaction
// evt_i    in   one operation: insert, remove head or clear, with event fields
// res_o    out  status, head entry and entry count after that operation
//
// Flow: one transaction per clock while the output register is free or read;
//   the result is registered on acceptance and shown from the next cycle.
//   Every cell compares against the new relevance and shifts in that same cycle.
// Reset: the count and the result valid are cleared; slot contents are left
//   as they are and are only read below the count.
// Stalls: evt_i.ready drops while a result waits unread in the output register.
// ---------------------------------------------------------------------------
module relevance_sorted_event_list
  import rsel_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rsel_in_if.sink    evt_i,
  rsel_out_if.source res_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             is_full, is_empty;
  rsel_ctrl_t       ctrl;
  rsel_status_e     status_d;

  logic      gt    [LIST_DEPTH];
  rsel_ent_t ent   [LIST_DEPTH];
  rsel_ent_t ent_d [LIST_DEPTH];

  // Output register
  logic         res_valid_q;
  rsel_status_e res_status_q;
  logic         res_head_valid_q;
  rsel_ent_t    res_head_q;
  logic [6:0]   res_count_q;

  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign accept      = evt_i.valid && evt_i.ready;
  assign is_full     = (count_q == CNT_W'(LIST_DEPTH));
  assign is_empty    = (count_q == '0);

  always_comb begin
    ctrl.ent.year  = evt_i.ev_year;
    ctrl.ent.month = evt_i.ev_month;
    ctrl.ent.day   = evt_i.ev_day;
    ctrl.ent.etype = evt_i.ev_type;
    ctrl.ent.rel   = evt_i.relevance;
    ctrl.ins       = 1'b0;
    ctrl.pop       = 1'b0;
    count_d        = count_q;
    status_d       = STAT_OK;
    if (accept) begin
      case (evt_i.kind)
        KIND_INSERT: begin
          if (is_full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (is_empty) begin
            status_d = STAT_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        KIND_CLEAR: begin
          count_d = '0;
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
  end

  // Cell row: each cell sees its left neighbor's flag and data and its right
  // neighbor's data. The head cell always takes the new entry when it loses.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic      left_gt;
    rsel_ent_t left_ent;
    rsel_ent_t right_ent;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b1;
      assign left_ent = ctrl.ent;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[i+1];
    end

    rsel_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CNT_W'(i) < count_q),
      .left_gt_i  (left_gt),
      .left_ent_i (left_ent),
      .right_ent_i(right_ent),
      .gt_o       (gt[i]),
      .ent_o      (ent[i]),
      .ent_d_o    (ent_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result of the accepted transaction; head is zero when empty.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q     <= status_d;
      res_head_valid_q <= (count_d != '0);
      res_head_q       <= (count_d != '0) ? ent_d[0] : '0;
      res_count_q      <= 7'(count_d);
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_status_q;
  assign res_o.head_valid     = res_head_valid_q;
  assign res_o.head_year      = res_head_q.year;
  assign res_o.head_month     = res_head_q.month;
  assign res_o.head_day       = res_head_q.day;
  assign res_o.head_type      = res_head_q.etype;
  assign res_o.head_relevance = res_head_q.rel;
  assign res_o.entry_count    = res_count_q;

endmodule

// ----- design/rsel_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsel_checker
// Port-level checks on the relevance sorted event list, bound to the top.
// ---------------------------------------------------------------------------
`include "relevance_sorted_event_list_defines.svh"

module rsel_checker
  import rsel_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_kind_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_status_i,
  input logic       res_head_valid_i,
  input logic [6:0] res_count_i
);

  `RSEL_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result dropped while stalled")
  `RSEL_ASSERT_NXT(a_clear_empty, in_valid_i && in_ready_i && in_kind_i == KIND_CLEAR, res_valid_i && res_count_i == 7'd0 && !res_head_valid_i, "clear did not empty the list")
  `RSEL_ASSERT_IMP(a_count_head, res_valid_i && res_count_i != 7'd0, res_head_valid_i, "nonzero count without head")
  `RSEL_ASSERT_IMP(a_full_count, res_valid_i && res_status_i == STAT_FULL, res_count_i == 7'(LIST_DEPTH), "full status with short list")
  `RSEL_ASSERT_IMP(a_ready_stall, !in_ready_i, res_valid_i && !res_ready_i, "input stalled without pending result")

endmodule

bind relevance_sorted_event_list rsel_checker u_rsel_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (evt_i.valid),
  .in_ready_i      (evt_i.ready),
  .in_kind_i       (evt_i.kind),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_status_i    (res_o.status),
  .res_head_valid_i(res_o.head_valid),
  .res_count_i     (res_o.entry_count)
);

// ----- dv/relevance_sorted_event_list_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// relevance_sorted_event_list_test
// Self-checking bench for the relevance sorted event list. A predictor keeps
// its own sorted copy of the list, works out the status, head entry and
// count for every accepted operation, and compares each result field by
// field. Stimulus runs from a short directed part into random fill, drain
// and mixed sequences under four sender/receiver idling profiles.
// ---------------------------------------------------------------------------
module relevance_sorted_event_list_test;
  import rsel_pkg::*;

  // Kind value with no operation behind it; the block must leave the list alone.
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam int PHASE_ITEMS    = 330;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // One result as seen on res_o, laid out in port order.
  typedef struct packed {
    logic [1:0] status;
    logic       head_valid;
    rsel_ent_t  head;
    logic [6:0] entry_count;
  } list_report_t;

  // -------------------------------------------------------------------------
  // Predictor: holds a sorted copy of the list and the results still owed.
  // -------------------------------------------------------------------------
  class relevance_list_predictor;
    rsel_ent_t    slots[LIST_DEPTH];
    int           fill;
    list_report_t owed_reports[$];
    int           errors;
    int           checked;
    int           n_insert, n_remove, n_clear, n_nop;
    int           n_full, n_empty, peak_fill;

    function new();
      fill      = 0;
      errors    = 0;
      checked   = 0;
      n_insert  = 0;
      n_remove  = 0;
      n_clear   = 0;
      n_nop     = 0;
      n_full    = 0;
      n_empty   = 0;
      peak_fill = 0;
    endfunction

    // Apply one accepted operation and queue the report it must produce.
    function void note_operation(logic [1:0] op, rsel_ent_t ent);
      list_report_t rpt;
      int           pos;
      rpt        = '0;
      rpt.status = STAT_OK;
      case (op)
        KIND_INSERT: begin
          n_insert++;
          if (fill >= LIST_DEPTH) begin
            rpt.status = STAT_FULL;
            n_full++;
          end else begin
            // Skip only strictly higher relevance: a new entry goes ahead of equals.
            pos = 0;
            while (pos < fill && slots[pos].rel > ent.rel) pos++;
            for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = ent;
            fill++;
          end
        end
        KIND_REMOVE: begin
          n_remove++;
          if (fill == 0) begin
            rpt.status = STAT_EMPTY;
            n_empty++;
          end else begin
            for (int i = 1; i < fill; i++) slots[i - 1] = slots[i];
            fill--;
          end
        end
        KIND_CLEAR: begin
          n_clear++;
          fill = 0;
        end
        default: n_nop++;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      if (fill > 0) begin
        rpt.head_valid = 1'b1;
        rpt.head       = slots[0];
      end
      rpt.entry_count = 7'(fill);
      owed_reports.push_back(rpt);
    endfunction

    function void match_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest report owed.
    function void check_report(list_report_t got);
      list_report_t want;
      if (owed_reports.size() == 0) begin
        $error("result transaction with no operation outstanding");
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      checked++;
      match_field("status",         16'(want.status),      16'(got.status));
      match_field("head_valid",     16'(want.head_valid),  16'(got.head_valid));
      match_field("head_year",      16'(want.head.year),   16'(got.head.year));
      match_field("head_month",     16'(want.head.month),  16'(got.head.month));
      match_field("head_day",       16'(want.head.day),    16'(got.head.day));
      match_field("head_type",      16'(want.head.etype),  16'(got.head.etype));
      match_field("head_relevance", 16'(want.head.rel),    16'(got.head.rel));
      match_field("entry_count",    16'(want.entry_count), 16'(got.entry_count));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // -------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rsel_in_if  evt_ch ();
  rsel_out_if res_ch ();

  relevance_sorted_event_list uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_ch),
    .res_o  (res_ch)
  );

  relevance_list_predictor sb;

  // Idling profile, changed between phases by the stimulus process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Stimulus-side view of the list depth, used to steer fill and drain runs.
  int shadow_fill = 0;
  int phase_sent  = 0;
  int stall_cycles = 0;

  // -------------------------------------------------------------------------
  // Monitor: both channels are sampled at the same edge, operations first,
  // so a result can never be checked ahead of the operation behind it.
  // Also drives the receiver stalls and runs the watchdog.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_report_t got;
    if (rst_ni) begin
      if (evt_ch.valid && evt_ch.ready)
        sb.note_operation(evt_ch.kind, {evt_ch.ev_year, evt_ch.ev_month, evt_ch.ev_day,
                                        evt_ch.ev_type, evt_ch.relevance});
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.status, res_ch.head_valid, res_ch.head_year, res_ch.head_month,
               res_ch.head_day, res_ch.head_type, res_ch.head_relevance,
               res_ch.entry_count};
        sb.check_report(got);
      end
      // Count cycles in which neither channel moves a transaction.
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("relevance_sorted_event_list_test: done, errors");
        $finish;
      end
    end
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // -------------------------------------------------------------------------
  // Driver tasks
  // -------------------------------------------------------------------------

  // Present one operation, idling first per the current profile, and hold
  // it until the block accepts it.
  task automatic issue_op(input logic [1:0] op, input rsel_ent_t ent);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_ch.valid     <= 1'b1;
    evt_ch.kind      <= op;
    evt_ch.ev_year   <= ent.year;
    evt_ch.ev_month  <= ent.month;
    evt_ch.ev_day    <= ent.day;
    evt_ch.ev_type   <= ent.etype;
    evt_ch.relevance <= ent.rel;
    @(posedge clk_i);
    while (!evt_ch.ready) @(posedge clk_i);
    case (op)
      KIND_INSERT: if (shadow_fill < LIST_DEPTH) shadow_fill++;
      KIND_REMOVE: if (shadow_fill > 0) shadow_fill--;
      KIND_CLEAR:  shadow_fill = 0;
      default: ;
    endcase
    phase_sent++;
  endtask

  function automatic rsel_ent_t mk_event(int yr, int mo, int dy, int ty, int rl);
    rsel_ent_t e;
    e.year  = 14'(yr);
    e.month = 4'(mo);
    e.day   = 5'(dy);
    e.etype = 4'(ty);
    e.rel   = 4'(rl);
    return e;
  endfunction

  // Mostly legal dates and relevance 0..9 so that ties are common; now and
  // then any bit pattern, which the block stores and sorts as given.
  function automatic rsel_ent_t random_event();
    if ($urandom_range(9) < 8)
      return mk_event($urandom_range(9999), $urandom_range(12, 1), $urandom_range(31, 1),
                      $urandom_range(10, 1), $urandom_range(9));
    return rsel_ent_t'(31'($urandom));
  endfunction

  // Insert until the list is full, then push a few refused inserts.
  task automatic fill_run();
    int extra;
    extra = $urandom_range(3, 1);
    while (shadow_fill < LIST_DEPTH) issue_op(KIND_INSERT, random_event());
    repeat (extra) issue_op(KIND_INSERT, random_event());
  endtask

  // Pop until empty, then a few removes on the empty list.
  task automatic drain_run();
    int extra;
    extra = $urandom_range(3, 1);
    while (shadow_fill > 0) issue_op(KIND_REMOVE, random_event());
    repeat (extra) issue_op(KIND_REMOVE, random_event());
  endtask

  // Random mix, leaning toward inserts so the list keeps some depth.
  task automatic mixed_run();
    int len;
    int pick;
    len = $urandom_range(40, 20);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 50)      issue_op(KIND_INSERT, random_event());
      else if (pick < 85) issue_op(KIND_REMOVE, random_event());
      else if (pick < 92) issue_op(KIND_CLEAR, random_event());
      else                issue_op(KIND_NOP, random_event());
    end
  endtask

  // One idling profile: a full fill and drain first, then random runs.
  task automatic run_phase(input int idle_pct, input int stall_pct);
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_sent     = 0;
    fill_run();
    drain_run();
    while (phase_sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60)      mixed_run();
      else if (pick < 75) fill_run();
      else if (pick < 90) drain_run();
      else                issue_op(KIND_CLEAR, random_event());
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    evt_ch.valid     <= 1'b0;
    evt_ch.kind      <= KIND_INSERT;
    evt_ch.ev_year   <= '0;
    evt_ch.ev_month  <= '0;
    evt_ch.ev_day    <= '0;
    evt_ch.ev_type   <= '0;
    evt_ch.relevance <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));                  // remove on empty
    issue_op(KIND_NOP, mk_event(16383, 15, 31, 15, 15));             // unused kind, empty
    issue_op(KIND_CLEAR, mk_event(0, 0, 0, 0, 0));                   // clear when empty
    issue_op(KIND_INSERT, mk_event(16383, 15, 31, 15, 15));          // all-ones fields
    issue_op(KIND_INSERT, mk_event(0, 0, 0, 0, 0));                  // all-zero fields
    issue_op(KIND_INSERT, mk_event(9999, 12, 31, 10, 9));            // top legal values
    issue_op(KIND_INSERT, mk_event(2024, 1, 1, 1, 9));               // tie: goes ahead
    issue_op(KIND_INSERT, mk_event(1, 6, 15, 5, 0));                 // tie at the tail
    issue_op(KIND_INSERT, mk_event(500, 3, 7, 2, 5));                // middle of the list
    issue_op(KIND_NOP, mk_event(1234, 5, 6, 7, 8));                  // unused kind, busy
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));                  // pop the 15
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));                  // pop newest 9
    issue_op(KIND_INSERT, mk_event(8191, 8, 16, 8, 10));             // above legal range
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));
    issue_op(KIND_CLEAR, mk_event(0, 0, 0, 0, 0));                   // clear with entries
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));                  // empty after clear
    issue_op(KIND_INSERT, mk_event(42, 2, 29, 3, 4));                // single entry
    issue_op(KIND_REMOVE, mk_event(0, 0, 0, 0, 0));                  // back to empty

    // Random part under each idling profile.
    run_phase(0, 0);
    run_phase(70, 0);
    run_phase(0, 70);
    run_phase(27, 27);

    // Drop valid at the edge that took the last operation.
    evt_ch.valid <= 1'b0;

    // Wait for every owed result, then give the block time to show strays.
    while (sb.owed_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts, %0d removes, %0d clears, %0d no-op kinds; peak depth %0d",
             sb.n_insert, sb.n_remove, sb.n_clear, sb.n_nop, sb.peak_fill);
    $display("refused on full %0d, removes on empty %0d, results checked %0d",
             sb.n_full, sb.n_empty, sb.checked);
    if (sb.errors == 0) begin
      $display("relevance_sorted_event_list_test: done, clean");
    end else begin
      $display("relevance_sorted_event_list_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/rsel_pkg.sv
design/rsel_if.sv
design/rsel_cell.sv
design/relevance_sorted_event_list.sv
design/rsel_checker.sv
dv/relevance_sorted_event_list_test.sv
